>>> rtl/lcazw_pkg.sv
// Shared types, constants and the sequencer microcode for the load-cell weigher.
// No dependencies.
package lcazw_pkg;

  localparam int DIV_STEPS = 36;  // |diff| * 2560 fits in 36 bits

  typedef enum logic [1:0] {
    REG_CPG        = 2'd0,
    REG_STABLE_BAND = 2'd1,
    REG_ZERO_BAND  = 2'd2,
    REG_ZERO_HITS  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_LOAD = 3'd1,
    ST_DIV  = 3'd2,
    ST_SAT  = 3'd3,
    ST_WR   = 3'd4,
    ST_SCAN = 3'd5,
    ST_DEC  = 3'd6,
    ST_OUT  = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV,
    ACT_SAT,
    ACT_WR,
    ACT_SCAN,
    ACT_DEC,
    ACT_OUT
  } act_t;

  typedef enum logic [1:0] {
    C_NEXT,    // advance
    C_ACCEPT,  // hold until a transaction; tare jumps to target
    C_LOOP,    // hold until the step counter reaches its limit
    C_OUT      // hold until the output register is free, then jump
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t cw;
    begin
      cw = '{act: ACT_NONE, cond: C_NEXT, target: ST_IDLE};
      case (pc)
        ST_IDLE: cw = '{act: ACT_NONE, cond: C_ACCEPT, target: ST_SCAN};
        ST_LOAD: cw = '{act: ACT_LOAD, cond: C_NEXT,   target: ST_IDLE};
        ST_DIV:  cw = '{act: ACT_DIV,  cond: C_LOOP,   target: ST_IDLE};
        ST_SAT:  cw = '{act: ACT_SAT,  cond: C_NEXT,   target: ST_IDLE};
        ST_WR:   cw = '{act: ACT_WR,   cond: C_NEXT,   target: ST_IDLE};
        ST_SCAN: cw = '{act: ACT_SCAN, cond: C_LOOP,   target: ST_IDLE};
        ST_DEC:  cw = '{act: ACT_DEC,  cond: C_NEXT,   target: ST_IDLE};
        ST_OUT:  cw = '{act: ACT_OUT,  cond: C_OUT,    target: ST_IDLE};
        default: cw = '{act: ACT_NONE, cond: C_NEXT,   target: ST_IDLE};
      endcase
      return cw;
    end
  endfunction

endpackage

>>> rtl/lcazw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcazw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/load_cell_auto_zero_weigher_unit.sv
// Load-cell weigher with auto-zero tracking: microcoded sequencer and datapath.
// Depends on lcazw_pkg and lcazw_ram.
// Weigh: load, 36-step restoring divide, saturate, ring write, ring scan through the
// single RAM read port, decide, output; next input taken in the cycle after the result
// is loaded. Tare skips straight to the scan. The output register holds a result while
// the next input is taken. Synchronous reset clears control state, offset, zero run and
// ring valid flags, and restores the default settings.
module load_cell_auto_zero_weigher_unit import lcazw_pkg::*; #(
  parameter int WINDOW_LEN = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] raw_count
  input  logic [1:0]  s_tuser,   // [0] op, [1] ready_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] grams_tenths
  output logic [1:0]  m_tuser,   // [0] stable, [1] rezeroed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW      = $clog2(WINDOW_LEN);
  localparam int CNT_MAX = (WINDOW_LEN + 1 > DIV_STEPS) ? WINDOW_LEN + 1 : DIV_STEPS;
  localparam int CNT_W   = $clog2(CNT_MAX);

  // config
  logic [23:0] counts_per_gram_q8;
  logic [15:0] stable_band_tenths;
  logic [15:0] zero_band_tenths;
  logic [7:0]  zero_hits_needed;

  // sequencer
  step_t            pc, pc_next;
  ctrl_t            cw;
  logic [CNT_W-1:0] cnt;
  logic             loop_last;
  logic             in_acc;
  logic             out_load;

  // state
  logic signed [23:0] zero_offset;
  logic [7:0]         near_zero_run;
  logic [AW-1:0]      write_slot;
  logic [WINDOW_LEN-1:0] ring_valid;

  // datapath
  logic               op_q;
  logic               ready_q;
  logic signed [23:0] raw_q;
  logic               neg;
  logic [35:0]        num;
  logic [23:0]        rem;
  logic [23:0]        den;
  logic signed [31:0] w_q;
  logic               near_q;
  logic signed [31:0] hi;
  logic signed [31:0] lo;
  logic               rd_v;
  logic               stab_q;
  logic               rez_q;

  logic [24:0]        diff;
  logic [24:0]        absd;
  logic [24:0]        rem_sh;
  logic [25:0]        trial;
  logic               scan_in;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        ram_rdata;
  logic signed [31:0] scan_val;
  logic [32:0]        spread;
  logic               stab;
  logic [7:0]         run_inc;
  logic               hit;

  assign pready   = 1'b1;
  assign s_tready = (pc == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_load = (cw.act == ACT_OUT) && (!m_tvalid || m_tready);

  assign cw = ucode(pc);

  assign loop_last = (cw.act == ACT_DIV) ? (cnt == CNT_W'(DIV_STEPS - 1))
                                         : (cnt == CNT_W'(WINDOW_LEN));

  always_comb begin
    pc_next = pc;
    case (cw.cond)
      C_NEXT:   pc_next = step_t'(pc + 3'd1);
      C_ACCEPT: begin
        if (in_acc) begin
          pc_next = s_tuser[0] ? cw.target : step_t'(pc + 3'd1);
        end
      end
      C_LOOP: begin
        if (loop_last) begin
          pc_next = step_t'(pc + 3'd1);
        end
      end
      C_OUT: begin
        if (out_load) begin
          pc_next = cw.target;
        end
      end
      default: pc_next = ST_IDLE;
    endcase
  end

  // arithmetic
  assign diff   = {raw_q[23], raw_q} - {zero_offset[23], zero_offset};
  assign absd   = diff[24] ? (25'd0 - diff) : diff;
  assign rem_sh = {rem, num[35]};
  assign trial  = {1'b0, rem_sh} - {2'b0, den};

  assign scan_in  = (cnt < CNT_W'(WINDOW_LEN));
  assign rd_addr  = scan_in ? cnt[AW-1:0] : '0;
  assign scan_val = rd_v ? $signed(ram_rdata) : 32'sd0;

  assign spread  = {hi[31], hi} - {lo[31], lo};
  assign stab    = spread < {17'd0, stable_band_tenths};
  assign run_inc = (near_zero_run == 8'hFF) ? near_zero_run : near_zero_run + 8'd1;
  assign hit     = (run_inc >= zero_hits_needed);

  lcazw_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (cw.act == ACT_WR),
    .waddr (write_slot),
    .wdata (w_q),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc                 <= ST_IDLE;
      cnt                <= '0;
      m_tvalid           <= 1'b0;
      counts_per_gram_q8 <= 24'd256;
      stable_band_tenths <= 16'd20;
      zero_band_tenths   <= 16'd50;
      zero_hits_needed   <= 8'd3;
      zero_offset        <= '0;
      near_zero_run      <= '0;
      write_slot         <= '0;
      ring_valid         <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= (cw.cond == C_LOOP && !loop_last) ? cnt + CNT_W'(1) : '0;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CPG:         counts_per_gram_q8 <= pwdata[23:0];
          REG_STABLE_BAND: stable_band_tenths <= pwdata[15:0];
          REG_ZERO_BAND:   zero_band_tenths   <= pwdata[15:0];
          REG_ZERO_HITS:   zero_hits_needed   <= pwdata[7:0];
          default: ;
        endcase
      end
      if (cw.act == ACT_WR) begin
        ring_valid[write_slot] <= 1'b1;
        write_slot <= (write_slot == AW'(WINDOW_LEN - 1)) ? '0 : write_slot + AW'(1);
      end
      if (cw.act == ACT_DEC) begin
        if (op_q) begin
          if (ready_q) begin
            zero_offset <= raw_q;
          end
        end else if (stab && near_q) begin
          if (hit) begin
            if (ready_q) begin
              zero_offset <= raw_q;
            end
            near_zero_run <= '0;
          end else begin
            near_zero_run <= run_inc;
          end
        end else begin
          near_zero_run <= '0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q    <= s_tuser[0];
      ready_q <= s_tuser[1];
      raw_q   <= $signed(s_tdata);
    end
    rd_v <= ring_valid[rd_addr];
    case (cw.act)
      ACT_LOAD: begin
        neg <= diff[24];
        num <= ready_q ? ({absd, 11'd0} + {2'd0, absd, 9'd0}) : '0;
        rem <= '0;
        den <= (counts_per_gram_q8 == 24'd0) ? 24'd1 : counts_per_gram_q8;
      end
      ACT_DIV: begin
        if (!trial[25]) begin
          rem <= trial[23:0];
          num <= {num[34:0], 1'b1};
        end else begin
          rem <= rem_sh[23:0];
          num <= {num[34:0], 1'b0};
        end
      end
      ACT_SAT: begin
        near_q <= (num < {20'd0, zero_band_tenths});
        if (neg) begin
          w_q <= (num > 36'h0_8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - num[31:0]);
        end else begin
          w_q <= (num > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(num[31:0]);
        end
      end
      ACT_SCAN: begin
        if (cnt == CNT_W'(1)) begin
          hi <= scan_val;
          lo <= scan_val;
        end else if (cnt != '0) begin
          if (scan_val > hi) hi <= scan_val;
          if (scan_val < lo) lo <= scan_val;
        end
      end
      ACT_DEC: begin
        stab_q <= stab;
        if (op_q) begin
          rez_q <= ready_q;
          w_q   <= '0;
        end else if (stab && near_q && hit) begin
          rez_q <= 1'b1;
          w_q   <= '0;
        end else begin
          rez_q <= 1'b0;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= w_q;
      m_tuser <= {rez_q, stab_q};
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_CPG:         prdata = {8'd0, counts_per_gram_q8};
      REG_STABLE_BAND: prdata = {16'd0, stable_band_tenths};
      REG_ZERO_BAND:   prdata = {16'd0, zero_band_tenths};
      REG_ZERO_HITS:   prdata = {24'd0, zero_hits_needed};
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/lcazw_checker.sv
// Port-level checks for the load-cell weigher, bound to the top level.
// Depends on load_cell_auto_zero_weigher_unit.
module lcazw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // one item in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // a re-zero or tare always reports zero weight
  a_rezero_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
    else $error("rezeroed result with non-zero weight");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind load_cell_auto_zero_weigher_unit lcazw_checker u_lcazw_checker (.*);

>>> dv/lcazw_scoreboard.sv
// Scoreboard for load_cell_auto_zero_weigher_unit: snoops the input, output and APB channels,
// predicts each weight reading and compares it with the result transaction.
// Depends on lcazw_pkg.
module lcazw_scoreboard import lcazw_pkg::*; #(
  parameter int   WINDOW_LEN = 6,
  parameter logic TARE_OP    = 1'b1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] raw_count
  input  logic [1:0]  s_tuser,   // [0] op, [1] ready_req
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] grams_tenths
  input  logic [1:0]  m_tuser,   // [0] stable, [1] rezeroed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] grams;
    logic               stable;
    logic               rezeroed;
  } reading_t;

  logic [23:0]        cpg_q8;
  logic [15:0]        stable_band;
  logic [15:0]        zero_band;
  logic [7:0]         hits_needed;
  logic signed [23:0] offset;
  logic signed [31:0] ring [WINDOW_LEN];
  int unsigned        slot;
  int unsigned        run_len;
  int                 errs;
  reading_t           expected_readings [$];

  function automatic logic ring_settled();
    longint lo, hi;
    int i;
    lo = ring[0];
    hi = ring[0];
    for (i = 1; i < WINDOW_LEN; i++) begin
      if (ring[i] < lo) lo = ring[i];
      if (ring[i] > hi) hi = ring[i];
    end
    return (hi - lo) < longint'(stable_band);
  endfunction

  function automatic reading_t predict_reading(input logic is_tare,
                                               input logic signed [23:0] raw,
                                               input logic arrived);
    reading_t r;
    longint w, den, mag;
    logic settled;
    w = 0;
    r.rezeroed = 1'b0;
    if (is_tare) begin
      if (arrived) begin
        offset = raw;
        r.rezeroed = 1'b1;
      end
      settled = ring_settled();
    end else begin
      if (slot >= WINDOW_LEN) slot = 0;
      if (arrived) begin
        den = (cpg_q8 == 0) ? 64'sd1 : longint'(cpg_q8);
        w = ((longint'(raw) - longint'(offset)) * 2560) / den;
        if (w > 64'sd2147483647) w = 64'sd2147483647;
        if (w < -64'sd2147483648) w = -64'sd2147483648;
      end
      ring[slot] = w[31:0];
      slot = (slot + 1) % WINDOW_LEN;
      settled = ring_settled();
      mag = (w < 0) ? -w : w;
      if (settled && mag < longint'(zero_band)) begin
        if (run_len < 255) run_len++;
        if (run_len >= hits_needed) begin
          if (arrived) offset = raw;
          run_len = 0;
          w = 0;
          r.rezeroed = 1'b1;
        end
      end else begin
        run_len = 0;
      end
    end
    r.grams = w[31:0];
    r.stable = settled;
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want, got;
    if (rst) begin
      cpg_q8 = 24'd256;
      stable_band = 16'd20;
      zero_band = 16'd50;
      hits_needed = 8'd3;
      offset = '0;
      for (int i = 0; i < WINDOW_LEN; i++) ring[i] = '0;
      slot = 0;
      run_len = 0;
      errs = 0;
      expected_readings.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CPG:         cpg_q8 = pwdata[23:0];
          REG_STABLE_BAND: stable_band = pwdata[15:0];
          REG_ZERO_BAND:   zero_band = pwdata[15:0];
          REG_ZERO_HITS:   hits_needed = pwdata[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.grams = $signed(m_tdata);
        got.stable = m_tuser[0];
        got.rezeroed = m_tuser[1];
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, got grams %0d stable %0b rezeroed %0b",
                   $time, got.grams, got.stable, got.rezeroed);
          errs++;
        end else begin
          want = expected_readings.pop_front();
          if (want.grams !== got.grams || want.stable !== got.stable ||
              want.rezeroed !== got.rezeroed) begin
            $display("%0t: expected grams %0d stable %0b rezeroed %0b, got grams %0d stable %0b rezeroed %0b",
                     $time, want.grams, want.stable, want.rezeroed,
                     got.grams, got.stable, got.rezeroed);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_readings.push_back(predict_reading(s_tuser[0] == TARE_OP, s_tdata, s_tuser[1]));
    end
    awaiting <= expected_readings.size();
    mismatches <= errs;
  end

endmodule

>>> dv/tb_load_cell_auto_zero_weigher_unit.sv
// Testbench top for load_cell_auto_zero_weigher_unit: directed and random weigh/tare stimulus,
// APB register phases and random back-pressure; verdict from lcazw_scoreboard.
// Depends on lcazw_pkg, lcazw_scoreboard and the RTL.
module tb_load_cell_auto_zero_weigher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lcazw_pkg::*;

  localparam logic OP_WEIGH    = 1'b0;
  localparam logic OP_TARE     = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   DRAIN       = 60;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [23:0] raw_count
  logic [1:0]  s_tuser;   // [0] op, [1] ready_req
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] grams_tenths
  logic [1:0]  m_tuser;   // [0] stable, [1] rezeroed
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          awaiting;
  int          cycles = 0;

  logic [23:0]        cpg_now;
  logic signed [23:0] centre;
  logic               quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  load_cell_auto_zero_weigher_unit dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lcazw_scoreboard #(.TARE_OP(OP_TARE)) scoreboard (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .awaiting
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result back-pressure in bursts, none once quiet
  always begin
    if (quiet || $urandom_range(0, 2) != 0) begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end else begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  task automatic wait_drained();
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_CPG) cpg_now = val[23:0];
  endtask

  task automatic set_weigher(input logic [23:0] cpg, input logic [15:0] sband,
                             input logic [15:0] zband, input logic [7:0] hits);
    s_tvalid <= 1'b0;
    wait_drained();
    apb_write(REG_CPG, {8'd0, cpg});
    apb_write(REG_STABLE_BAND, {16'd0, sband});
    apb_write(REG_ZERO_BAND, {16'd0, zband});
    apb_write(REG_ZERO_HITS, {24'd0, hits});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send(input logic op, input logic [23:0] raw, input logic arrived);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    s_tuser <= {arrived, op};
    do @(posedge clk); while (!s_tready);
    if (op == OP_TARE && arrived) centre = raw;
  endtask

  // mostly readings close to the tare point so the ring settles and re-zeroes
  task automatic random_reading();
    int k, nmax, d;
    logic [23:0] raw;
    logic op, arrived;
    k = $urandom_range(0, 99);
    nmax = int'(cpg_now >> 7) + 2;
    d = int'($urandom_range(0, 2 * nmax)) - nmax;
    raw = centre + d[23:0];
    op = OP_WEIGH;
    arrived = 1'b1;
    if (k < 8) begin
      op = OP_TARE;
      arrived = (k != 0);
      if (k < 4) raw = 24'($urandom);
    end else if (k < 13) begin
      arrived = 1'b0;
      raw = 24'($urandom);
    end else if (k < 33) begin
      raw = 24'($urandom);
    end
    send(op, raw, arrived);
  endtask

  initial begin
    int p;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cpg_now = 24'd256;
    centre = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero run to re-zero, extremes, timed-out reads, tare
    repeat (3) send(OP_WEIGH, 24'h000000, 1'b1);
    send(OP_WEIGH, 24'h7FFFFF, 1'b1);
    send(OP_WEIGH, 24'h800000, 1'b1);
    send(OP_WEIGH, 24'h000005, 1'b0);
    send(OP_TARE, 24'h7FFFFF, 1'b1);
    send(OP_WEIGH, 24'h800000, 1'b1);
    send(OP_TARE, 24'h123456, 1'b0);
    send(OP_WEIGH, 24'h7FFFFF, 1'b1);

    // unit scale: saturation both ways, never stable
    set_weigher(24'd1, 16'd0, 16'd0, 8'd0);
    send(OP_TARE, 24'h7FFFFF, 1'b1);
    send(OP_WEIGH, 24'h800000, 1'b1);
    send(OP_TARE, 24'h800000, 1'b1);
    send(OP_WEIGH, 24'h7FFFFF, 1'b1);
    send(OP_WEIGH, 24'h800000, 1'b1);

    // zero scale and zero hit count, widest bands
    set_weigher(24'd0, 16'hFFFF, 16'hFFFF, 8'd0);
    send(OP_TARE, 24'h000000, 1'b1);
    repeat (7) send(OP_WEIGH, 24'($urandom), 1'b0);
    send(OP_WEIGH, 24'h000001, 1'b1);

    set_weigher(24'd256, 16'd20, 16'd50, 8'd3);
    repeat (50) random_reading();

    // full run counter before each re-zero
    set_weigher(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
    repeat (270) random_reading();

    set_weigher(24'd1, 16'hFFFF, 16'hFFFF, 8'd1);
    repeat (45) random_reading();

    for (p = 0; p < 3; p++) begin
      set_weigher(24'($urandom_range(128, 4096)), 16'($urandom_range(5, 200)),
                  16'($urandom_range(10, 500)), 8'($urandom_range(1, 8)));
      repeat (50) random_reading();
    end

    set_weigher(24'd640, 16'd40, 16'd100, 8'd2);
    quiet = 1'b1;
    repeat (60) random_reading();

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
